// ===== sv/jpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON pair tokenizer package
// Shared types, character codes and helpers for the tokenizer blocks.
// ----------------------------------------------------------------------------
package jpt_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [2:0] {
		TK_KEY   = 3'd0,
		TK_VAL   = 3'd1,
		TK_PAIR  = 3'd2,
		TK_CLOSE = 3'd3,
		TK_END   = 3'd4,
		TK_ERR   = 3'd5
	} tok_kind_t;

	typedef enum logic [5:0] {
		PH_START   = 6'b000001,
		PH_KEY     = 6'b000010,
		PH_KEY_END = 6'b000100,
		PH_VAL     = 6'b001000,
		PH_VAL_END = 6'b010000,
		PH_NEXT    = 6'b100000
	} phase_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] chr;
		logic       last;
	} token_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     tok0;
		token_t     tok1;
	} tok_bundle_t;

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== sv/jpt_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON pair tokenizer parser
// Holds the parse state and decodes one byte into at most two tokens.
// ----------------------------------------------------------------------------
module jpt_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          chr,
	input  logic                fin,
	output jpt_pkg::tok_bundle_t bundle
);
	import jpt_pkg::*;

	phase_t     phase_q;
	logic       esc_q;
	logic       done_q;
	phase_t     ph_d;
	logic       esc_d;
	logic       done_d;
	logic [1:0] n;
	tok_kind_t  k0;
	tok_kind_t  k1;
	tok_kind_t  str_kind;
	logic [7:0] c0;

	always_comb begin
		ph_d     = phase_q;
		esc_d    = esc_q;
		done_d   = done_q;
		n        = 2'd0;
		k0       = TK_KEY;
		k1       = TK_KEY;
		c0       = 8'h00;
		str_kind = (phase_q == PH_KEY) ? TK_KEY : TK_VAL;
		if (!done_q) begin
			unique case (phase_q)
				PH_KEY, PH_VAL: begin
					priority if (esc_q) begin
						esc_d = 1'b0;
						n     = 2'd1;
						k0    = str_kind;
						c0    = chr;
					end else if ((chr == CH_BSLASH) && !fin) begin
						esc_d = 1'b1;
					end else if (chr == CH_QUOTE) begin
						ph_d = (phase_q == PH_KEY) ? PH_KEY_END : PH_VAL_END;
					end else begin
						n  = 2'd1;
						k0 = str_kind;
						c0 = chr;
					end
				end
				PH_KEY_END: begin
					priority if (is_space(chr) || (chr == CH_COLON)) begin
					end else if (chr == CH_QUOTE) begin
						ph_d = PH_VAL;
					end else begin
						n      = 2'd1;
						k0     = TK_ERR;
						done_d = 1'b1;
					end
				end
				PH_VAL_END: begin
					priority if (is_space(chr)) begin
					end else if (chr == CH_COMMA) begin
						n    = 2'd1;
						k0   = TK_PAIR;
						ph_d = PH_NEXT;
					end else if (chr == CH_RBRACE) begin
						n      = 2'd2;
						k0     = TK_PAIR;
						k1     = TK_CLOSE;
						done_d = 1'b1;
					end else begin
						n      = 2'd1;
						k0     = TK_ERR;
						done_d = 1'b1;
					end
				end
				PH_NEXT: begin
					priority if (is_space(chr)) begin
					end else if (chr == CH_QUOTE) begin
						ph_d = PH_KEY;
					end else begin
						n      = 2'd1;
						k0     = TK_ERR;
						done_d = 1'b1;
					end
				end
				default: begin
					priority if (is_space(chr) || (chr == CH_LBRACE)) begin
					end else if (chr == CH_QUOTE) begin
						ph_d = PH_KEY;
					end else begin
						n      = 2'd1;
						k0     = TK_ERR;
						done_d = 1'b1;
					end
				end
			endcase
		end
		if (fin) begin
			if (!done_d) begin
				if (n == 2'd0) begin
					k0 = TK_END;
				end else begin
					k1 = TK_END;
				end
				n = n + 2'd1;
			end
			ph_d   = PH_START;
			esc_d  = 1'b0;
			done_d = 1'b0;
		end
	end

	assign bundle.n         = n;
	assign bundle.tok0.kind = k0;
	assign bundle.tok0.chr  = c0;
	assign bundle.tok0.last = (n == 2'd1);
	assign bundle.tok1.kind = k1;
	assign bundle.tok1.chr  = 8'h00;
	assign bundle.tok1.last = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			esc_q   <= 1'b0;
			done_q  <= 1'b0;
		end else if (step) begin
			phase_q <= ph_d;
			esc_q   <= esc_d;
			done_q  <= done_d;
		end
	end

	a_esc_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (phase_q == PH_KEY) || (phase_q == PH_VAL))
		else $error("Escape pending outside a string.");

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && fin) |=> (phase_q == PH_START) && !esc_q && !done_q)
		else $error("Final byte did not return the parser to its start state.");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !fin) |-> (n == 2'd0))
		else $error("Token produced while the object is finished.");

endmodule

// ===== sv/jpt_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON pair tokenizer output queue
// Small token queue: up to two tokens in per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module jpt_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  jpt_pkg::tok_bundle_t     bundle,
	output logic [jpt_pkg::Q_CW-1:0] level,
	output logic                     head_valid,
	output jpt_pkg::token_t          head,
	input  logic                     head_stall
);
	import jpt_pkg::*;

	token_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   cnt_q;
	logic [1:0]        push_n;
	logic              pop;

	assign push_n     = push ? bundle.n : 2'd0;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign pop        = head_valid && !head_stall;
	assign level      = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= bundle.tok0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + Q_AW'(1)] <= bundle.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + Q_AW'(pop);
			cnt_q    <= cnt_q + Q_CW'(push_n) - Q_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + (Q_CW + 1)'(push_n)) <= (Q_CW + 1)'(Q_DEPTH))
		else $error("Token queue overflow.");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CW'(Q_DEPTH))
		else $error("Token queue level out of range.");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (push_n == 2'd0)) |=> (cnt_q == $past(cnt_q) - Q_CW'(1)))
		else $error("Token queue level wrong after a lone transfer out.");

endmodule

// ===== sv/flat_json_pair_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flat JSON pair tokenizer
// Turns a flat JSON object, one byte per transfer, into tagged tokens.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  input    in         in_valid / in_stall  char_in, is_final
//  output   out        out_valid/out_stall  token_kind, token_char, run_end
//
//  One byte is taken per cycle while in_stall is low; a byte's tokens pass
//  through the input register into a four-entry queue, which gives one token
//  per cycle while out_stall is low. The input stalls only when the queue
//  cannot take the tokens, one or two, of the registered byte.
//  Reset clears the parse state, the input register and the queue.
//  Output stall holds the queue head and the input stall follows queue level.
// ----------------------------------------------------------------------------
module flat_json_pair_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] token_kind,
	output logic [7:0] token_char,
	output logic       run_end
);
	import jpt_pkg::*;

	logic              vld_s1;
	logic [7:0]        chr_s1;
	logic              fin_s1;
	logic              consume;
	logic [Q_CW-1:0]   level;
	tok_bundle_t       bundle;
	token_t            head;

	assign consume  = vld_s1 &&
		(({1'b0, level} + (Q_CW + 1)'(bundle.n)) <= (Q_CW + 1)'(Q_DEPTH));
	assign in_stall = vld_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			chr_s1 <= char_in;
			fin_s1 <= is_final;
		end
	end

	jpt_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.chr    (chr_s1),
		.fin    (fin_s1),
		.bundle (bundle)
	);

	jpt_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (consume),
		.bundle     (bundle),
		.level      (level),
		.head_valid (out_valid),
		.head       (head),
		.head_stall (out_stall)
	);

	assign token_kind = head.kind;
	assign token_char = head.chr;
	assign run_end    = head.last;

endmodule
